@@ design/wqs_pkg.sv @@
// package for the wheel quadrature scaler: widths, codes, reset values
// and the gray-sequence step functions; depends on nothing
`default_nettype none

package wqs_pkg;

  // field and state widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned PinW    = 2;
  localparam int unsigned SensorW = 16;
  localparam int unsigned DeltaW  = 8;
  localparam int unsigned StepsW  = 11;
  localparam int unsigned DivW    = 7;
  localparam int unsigned AccW    = 18;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = StepsW;

  // shared divider: dividend, divisor and quotient magnitudes
  localparam int unsigned QuoW = AccW;
  localparam int unsigned CntW = $clog2(QuoW);

  // degrees added per quadrature step
  localparam logic signed [AccW:0] FullTurnDeg = (AccW + 1)'(360);

  // register reset values
  localparam logic [StepsW-1:0] StepsReset  = StepsW'(24);
  localparam logic [DivW-1:0]   DivReset    = DivW'(1);

  // item operation codes
  typedef enum logic [OpW-1:0] {
    OP_PIN_CHANGE = 2'd0,
    OP_RESYNC     = 2'd1,
    OP_SENSOR     = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPS_PER_TURN = 2'd0,
    CFG_VALUE_DIVIDER  = 2'd1,
    CFG_INVERT_AXIS    = 2'd2
  } cfg_idx_t;

  // next entry of the sequence 00,10,11,01 (B A)
  function automatic logic [PinW-1:0] gray_fwd(input logic [PinW-1:0] p);
    logic [PinW-1:0] r;
    unique case (p)
      2'b00: r = 2'b10;
      2'b10: r = 2'b11;
      2'b11: r = 2'b01;
      2'b01: r = 2'b00;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  // previous entry, wrapping from 00 back to 01
  function automatic logic [PinW-1:0] gray_back(input logic [PinW-1:0] p);
    logic [PinW-1:0] r;
    unique case (p)
      2'b00: r = 2'b01;
      2'b10: r = 2'b00;
      2'b11: r = 2'b10;
      2'b01: r = 2'b11;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/wqs_if.sv @@
// item channels of the wheel quadrature scaler: input and result interfaces
// depends on wqs_pkg for field widths
`default_nettype none

interface wqs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [wqs_pkg::OpW-1:0]                operation;
  logic [wqs_pkg::PinW-1:0]               pin_levels;
  logic [wqs_pkg::PinW-1:0]               changed_pins;
  logic signed [wqs_pkg::SensorW-1:0]     sensor_rotation;

  modport source (output valid, operation, pin_levels, changed_pins, sensor_rotation,
                  input ready);
  modport sink   (input valid, operation, pin_levels, changed_pins, sensor_rotation,
                  output ready);
endinterface

interface wqs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wqs_pkg::DeltaW-1:0]    wheel_delta;

  modport source (output valid, wheel_delta, input ready);
  modport sink   (input valid, wheel_delta, output ready);
endinterface

`default_nettype wire

@@ design/wheel_quadrature_scaler.sv @@
// top level of the wheel quadrature scaler: x4 decoder, accumulator and
// a shared serial divider; depends on wqs_pkg and the wqs_in_if/wqs_out_if channels
`default_nettype none

// A pin-change item advances a 4x quadrature decoder and adds or subtracts 360
// to an 18-bit angle accumulator; once its magnitude reaches steps_per_turn times
// value_divider a turn count is split off and reported as one wheel_delta item.
// A sensor item reports its rotation value scaled by value_divider. Both divisions
// run on one restoring divider, one quotient bit per cycle. A reporting pin-change
// item passes S_CHECK, S_DIV and S_DONE, a sensor item S_DIV and S_DONE; S_DONE
// waits while an earlier result is untaken, and items are taken only in S_IDLE.
// A pin-change item that reports nothing passes S_CHECK at most and a resync item
// is done on acceptance. The block takes one item at a time; a finished result
// waits in an output register and the next item is accepted meanwhile.
module wheel_quadrature_scaler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wqs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [wqs_pkg::CfgDataW-1:0]  cfg_data,
  wqs_in_if.sink                             din,
  wqs_out_if.source                          dout
);

  localparam int unsigned AccW   = wqs_pkg::AccW;
  localparam int unsigned QuoW   = wqs_pkg::QuoW;
  localparam int unsigned CntW   = wqs_pkg::CntW;
  localparam int unsigned DeltaW = wqs_pkg::DeltaW;
  localparam int unsigned StepsW = wqs_pkg::StepsW;
  localparam int unsigned DivW   = wqs_pkg::DivW;
  localparam int unsigned PinW   = wqs_pkg::PinW;
  localparam int unsigned SensorW = wqs_pkg::SensorW;

  localparam logic [CntW-1:0] LastIter = CntW'(QuoW - 1);
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [QuoW-1:0] PosLimit = QuoW'(127);
  localparam logic [QuoW-1:0] NegLimit = QuoW'(128);
  localparam logic [DeltaW-1:0] DeltaMax = {1'b0, {(DeltaW-1){1'b1}}};
  localparam logic [DeltaW-1:0] DeltaMin = {1'b1, {(DeltaW-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  // configuration
  logic [StepsW-1:0]          steps_per_turn;
  logic [DivW-1:0]            value_divider;
  logic                       invert_axis;

  // block state
  state_t                     state;
  logic [PinW-1:0]            pin_pair;
  logic signed [AccW-1:0]     angle_accumulator;

  // divider and item context
  logic [AccW-1:0]            div_rem;
  logic [QuoW-1:0]            div_quo;
  logic [AccW-1:0]            div_den;
  logic [CntW-1:0]            div_cnt;
  logic                       is_pin;
  logic                       neg_acc;
  logic                       neg_out;

  // result register
  logic                       out_valid;
  logic [DeltaW-1:0]          out_delta;

  // combinational terms
  logic [StepsW-1:0]          steps_eff;
  logic [DivW-1:0]            div_eff;
  logic [AccW-1:0]            threshold;
  logic [PinW-1:0]            pin_next;
  logic                       step_fwd;
  logic                       step_back;
  logic signed [AccW:0]       acc_sum;
  logic signed [AccW-1:0]     acc_sat;
  logic [AccW-1:0]            acc_mag;
  logic                       sensor_neg;
  logic [AccW-1:0]            sensor_mag;
  logic [AccW:0]              rem_shift;
  logic                       rem_ge;
  logic [AccW-1:0]            rem_next;
  logic [DeltaW-1:0]          delta_sat;
  logic                       in_fire;
  logic                       out_free;

  assign in_fire  = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;

  assign din.ready        = (state == S_IDLE);
  assign dout.valid       = out_valid;
  assign dout.wheel_delta = out_delta;

  // zero-valued registers act as one
  assign steps_eff = (steps_per_turn == '0) ? StepsW'(1) : steps_per_turn;
  assign div_eff   = (value_divider == '0) ? DivW'(1) : value_divider;
  assign threshold = AccW'(AccW'(steps_eff) * AccW'(div_eff));

  // quadrature step detection
  always_comb begin
    pin_next  = (din.pin_levels & din.changed_pins) | (pin_pair & ~din.changed_pins);
    step_fwd  = (pin_next == wqs_pkg::gray_fwd(pin_pair));
    step_back = (pin_next == wqs_pkg::gray_back(pin_pair));
  end

  // accumulator step with saturation to the signed range
  always_comb begin
    acc_sum = {angle_accumulator[AccW-1], angle_accumulator}
              + (step_fwd ? wqs_pkg::FullTurnDeg : -wqs_pkg::FullTurnDeg);
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  // magnitudes fed to the divider
  assign acc_mag    = angle_accumulator[AccW-1] ? AccW'(-angle_accumulator)
                                                : AccW'(angle_accumulator);
  assign sensor_neg = din.sensor_rotation[SensorW-1];
  assign sensor_mag = sensor_neg ? AccW'(-(AccW'(signed'(din.sensor_rotation))))
                                 : AccW'(din.sensor_rotation);

  // one restoring divider step
  always_comb begin
    rem_shift = {div_rem, div_quo[QuoW-1]};
    rem_ge    = (rem_shift >= {1'b0, div_den});
    rem_next  = rem_ge ? AccW'(rem_shift - {1'b0, div_den}) : rem_shift[AccW-1:0];
  end

  // signed, saturated report from the quotient magnitude
  always_comb begin
    if (neg_out) begin
      delta_sat = (div_quo > NegLimit) ? DeltaMin : DeltaW'(-div_quo[DeltaW-1:0]);
    end else begin
      delta_sat = (div_quo > PosLimit) ? DeltaMax : div_quo[DeltaW-1:0];
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      steps_per_turn    <= wqs_pkg::StepsReset;
      value_divider     <= wqs_pkg::DivReset;
      invert_axis       <= 1'b0;
      pin_pair          <= '0;
      angle_accumulator <= '0;
      out_valid         <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          wqs_pkg::CFG_STEPS_PER_TURN: steps_per_turn <= cfg_data;
          wqs_pkg::CFG_VALUE_DIVIDER:  value_divider  <= cfg_data[DivW-1:0];
          wqs_pkg::CFG_INVERT_AXIS:    invert_axis    <= cfg_data[0];
          default: ;
        endcase
      end

      // a taken result clears, unless a new one is loaded in the same cycle
      if (out_valid && dout.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (din.operation)
              wqs_pkg::OP_PIN_CHANGE: begin
                pin_pair <= pin_next;
                if (step_fwd || step_back) begin
                  angle_accumulator <= acc_sat;
                  state             <= S_CHECK;
                end
              end
              wqs_pkg::OP_RESYNC: begin
                pin_pair <= din.pin_levels;
              end
              wqs_pkg::OP_SENSOR: begin
                is_pin  <= 1'b0;
                neg_out <= sensor_neg ^ !invert_axis;
                div_rem <= '0;
                div_quo <= sensor_mag;
                div_den <= AccW'(div_eff);
                div_cnt <= '0;
                state   <= S_DIV;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (acc_mag >= threshold) begin
            is_pin  <= 1'b1;
            neg_acc <= angle_accumulator[AccW-1];
            neg_out <= angle_accumulator[AccW-1] ^ !invert_axis;
            div_rem <= '0;
            div_quo <= acc_mag;
            div_den <= threshold;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          div_rem <= rem_next;
          div_quo <= {div_quo[QuoW-2:0], rem_ge};
          div_cnt <= div_cnt + CntW'(1);
          if (div_cnt == LastIter) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (is_pin) begin
              angle_accumulator <= neg_acc ? AccW'(-div_rem) : AccW'(div_rem);
            end
            out_delta <= delta_sat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/wqs_checker.sv @@
// port-level checks for the wheel quadrature scaler and their bind
// depends on wqs_pkg and the top level wheel_quadrature_scaler
`default_nettype none

module wqs_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [wqs_pkg::OpW-1:0]             in_operation,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [wqs_pkg::DeltaW-1:0]          out_wheel_delta
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel_delta))
    else $error("result dropped or changed while stalled");

  // resync and unused items never produce a result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready
    && (in_operation == wqs_pkg::OP_RESYNC || in_operation == wqs_pkg::OP_UNUSED)
    |=> !$rose(out_valid))
    else $error("result from an item that reports nothing");

  // a result only appears after a busy cycle
  a_busy_before_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind wheel_quadrature_scaler wqs_checker u_wqs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (din.valid),
  .in_ready        (din.ready),
  .in_operation    (din.operation),
  .out_valid       (dout.valid),
  .out_ready       (dout.ready),
  .out_wheel_delta (dout.wheel_delta)
);

`default_nettype wire
